FILE: sv/intel_hex_record_checker_assert.svh
// assertion macros for the intel hex record checker
// clocked on aclk; the checked variant is disabled while aresetn is low
`ifndef INTEL_HEX_RECORD_CHECKER_ASSERT_SVH
`define INTEL_HEX_RECORD_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
`define IHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define IHC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define IHC_ASSERT(label, prop, msg)
`define IHC_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: sv/ihc_pkg.sv
package ihc_pkg;

    localparam int MAX_DATA_BYTES = 32;
    localparam int LINE_CHARS     = 100;
    localparam int LINE_DIGITS    = LINE_CHARS - 2;

    // most digits a line may carry
    localparam logic [7:0] DIGIT_LIMIT = (LINE_DIGITS > 255) ? 8'd255 : 8'(LINE_DIGITS);
    localparam logic [7:0] MAX_COUNT   = 8'(MAX_DATA_BYTES);
    localparam logic [7:0] MIN_DIGITS  = 8'd10;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] REC_DATA       = 8'h00;
    localparam logic [7:0] REC_EOF        = 8'h01;
    localparam logic [7:0] REC_EXT_LINEAR = 8'h04;

    localparam logic [31:0] LOWEST_RESET   = 32'hFFFF_FFFF;
    localparam logic [15:0] FIRST_DATA_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_COLON    = 3'd1,
        ST_TOO_SHORT   = 3'd2,
        ST_COUNT_LARGE = 3'd3,
        ST_BAD_SUM     = 3'd4,
        ST_BAD_TYPE    = 3'd5
    } status_t;

    // record fields gathered so far
    typedef struct packed {
        logic [7:0]  digits;
        logic [7:0]  sum;
        logic [7:0]  count;
        logic [15:0] address;
        logic [7:0]  rtype;
        logic [15:0] first_data;
    } rec_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic take;
    } asm_ctl_t;

    typedef struct packed {
        logic clear;
        logic no_colon;
        logic finish;
    } eval_ctl_t;

    typedef struct packed {
        logic        stopped;
        logic        file_valid;
        logic [31:0] max_addr;
        logic [31:0] min_addr;
        logic [7:0]  count;
        logic [31:0] address;
        logic [7:0]  rtype;
        status_t     status;
    } result_t;

endpackage

FILE: sv/ihc_rec_asm.sv
// pairs hex digits into bytes and captures the header and first data bytes
module ihc_rec_asm (
    input  logic             aclk,
    input  logic             aresetn,
    input  ihc_pkg::asm_ctl_t ctl,
    input  logic [3:0]       digit,
    output ihc_pkg::rec_t    rec
);

    ihc_pkg::rec_t rec_reg, rec_next;
    logic [3:0]    high_nibble_reg, high_nibble_next;
    logic [7:0]    byte_val;
    logic [6:0]    byte_idx;

    assign byte_val = {high_nibble_reg, digit};
    assign byte_idx = rec_reg.digits[7:1];

    always_comb begin
        rec_next         = rec_reg;
        high_nibble_next = high_nibble_reg;
        if (ctl.clear || ctl.start) begin
            rec_next            = '0;
            rec_next.first_data = ihc_pkg::FIRST_DATA_RESET;
            high_nibble_next    = '0;
        end else if (ctl.take) begin
            rec_next.digits = rec_reg.digits + 8'd1;
            if (!rec_reg.digits[0]) begin
                high_nibble_next = digit;
            end else begin
                rec_next.sum = rec_reg.sum + byte_val;
                case (byte_idx)
                    7'd0: rec_next.count = byte_val;
                    7'd1: rec_next.address[15:8] = byte_val;
                    7'd2: rec_next.address[7:0] = byte_val;
                    7'd3: rec_next.rtype = byte_val;
                    7'd4: begin
                        if (rec_reg.count >= 8'd1) rec_next.first_data[15:8] = byte_val;
                    end
                    7'd5: begin
                        if (rec_reg.count >= 8'd2) rec_next.first_data[7:0] = byte_val;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg            <= '0;
            rec_reg.first_data <= ihc_pkg::FIRST_DATA_RESET;
            high_nibble_reg    <= '0;
        end else begin
            rec_reg         <= rec_next;
            high_nibble_reg <= high_nibble_next;
        end
    end

    assign rec = rec_reg;

endmodule

FILE: sv/ihc_rec_eval.sv
// checks a finished record, keeps the file-wide offset and address range
module ihc_rec_eval #(
    parameter int MAX_DATA_BYTES = ihc_pkg::MAX_DATA_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ihc_pkg::eval_ctl_t ctl,
    input  ihc_pkg::rec_t      rec,
    output ihc_pkg::result_t   res
);

    localparam logic [7:0] MAX_COUNT = 8'(MAX_DATA_BYTES);

    logic [15:0] offset_reg, offset_next, cur_offset;
    logic [31:0] lowest_reg, lowest_next, cur_lowest;
    logic [31:0] highest_reg, highest_next, cur_highest;
    logic        eof_reg, eof_next, cur_eof;

    logic [31:0] addr_cur;
    logic [31:0] end_addr;
    logic        too_short;
    logic        length_ok;
    ihc_pkg::status_t status;

    assign cur_offset  = ctl.clear ? 16'd0 : offset_reg;
    assign cur_lowest  = ctl.clear ? ihc_pkg::LOWEST_RESET : lowest_reg;
    assign cur_highest = ctl.clear ? 32'd0 : highest_reg;
    assign cur_eof     = ctl.clear ? 1'b0 : eof_reg;

    assign addr_cur  = {cur_offset, rec.address};
    assign end_addr  = addr_cur + {24'd0, rec.count};
    assign too_short = rec.digits < ihc_pkg::MIN_DIGITS;
    assign length_ok = {2'd0, rec.digits} == (10'(ihc_pkg::MIN_DIGITS) + {1'b0, rec.count, 1'b0});

    always_comb begin
        if (rec.count > MAX_COUNT) begin
            status = ihc_pkg::ST_COUNT_LARGE;
        end else if (!length_ok || rec.sum != 8'd0) begin
            status = ihc_pkg::ST_BAD_SUM;
        end else if (rec.rtype == ihc_pkg::REC_DATA || rec.rtype == ihc_pkg::REC_EOF ||
                     rec.rtype == ihc_pkg::REC_EXT_LINEAR) begin
            status = ihc_pkg::ST_OK;
        end else begin
            status = ihc_pkg::ST_BAD_TYPE;
        end
    end

    always_comb begin
        offset_next  = cur_offset;
        lowest_next  = cur_lowest;
        highest_next = cur_highest;
        eof_next     = cur_eof;
        if (ctl.finish && !too_short && status == ihc_pkg::ST_OK) begin
            case (rec.rtype)
                ihc_pkg::REC_DATA: begin
                    if (addr_cur < cur_lowest) lowest_next = addr_cur;
                    if (end_addr > cur_highest) highest_next = end_addr;
                end
                ihc_pkg::REC_EOF:        eof_next = 1'b1;
                ihc_pkg::REC_EXT_LINEAR: offset_next = rec.first_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        res            = '0;
        res.min_addr   = lowest_next;
        res.max_addr   = highest_next;
        res.file_valid = eof_next;
        res.stopped    = 1'b1;
        if (ctl.no_colon) begin
            res.status = ihc_pkg::ST_NO_COLON;
        end else if (too_short) begin
            res.status = ihc_pkg::ST_TOO_SHORT;
        end else begin
            res.status  = status;
            res.rtype   = rec.rtype;
            res.count   = rec.count;
            res.address = {offset_next, rec.address};
            res.stopped = (status != ihc_pkg::ST_OK) || (rec.rtype == ihc_pkg::REC_EOF);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            lowest_reg  <= ihc_pkg::LOWEST_RESET;
            highest_reg <= '0;
            eof_reg     <= 1'b0;
        end else begin
            offset_reg  <= offset_next;
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            eof_reg     <= eof_next;
        end
    end

endmodule

FILE: sv/intel_hex_record_checker.sv
// intel hex record checker: takes a hex file one ascii character per transaction and
// gives one result transaction for each finished line (status, decoded header fields and
// the running address range). a character is taken every cycle: it sits in an input
// register while it is decoded and checked, and the result register is loaded as it
// moves on, so each result is offered after its terminating character has
// left the input register. the only limit on rate is the result register: while a result
// waits for m_tready the input side stalls as well. MAX_DATA_BYTES bounds the count byte
// and LINE_CHARS - 2 (at most 255) the digits on one line. a set new_file bit clears all
// scan state before its character is handled; after end of file or any error every
// character is dropped silently until the next new_file
`include "intel_hex_record_checker_assert.svh"

module intel_hex_record_checker #(
    parameter int MAX_DATA_BYTES = ihc_pkg::MAX_DATA_BYTES,
    parameter int LINE_CHARS     = ihc_pkg::LINE_CHARS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input characters
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // new_file[0], ch[8:1], zero pad
    // record results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // status[2:0], record_type[10:3], record_address[42:11],
                                    // byte_count[50:43], min_address[82:51],
                                    // max_address[114:83], file_valid[115],
                                    // scan_stopped[116], zero pad
);

    localparam int         LINE_DIGITS = LINE_CHARS - 2;
    // most digits a line may carry
    localparam logic [7:0] DIGIT_LIMIT = (LINE_DIGITS > 255) ? 8'd255 : 8'(LINE_DIGITS);

    typedef enum logic [1:0] {
        PH_LINE_START,
        PH_DIGITS,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.valid = 1'b1;
            d.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            // upper and lower case share the low nibble offset
            d.valid = 1'b1;
            d.value = c[3:0] + 4'd9;
        end
        return d;
    endfunction

    // input register
    logic       in_valid_reg;
    logic       in_new_file_reg;
    logic [7:0] in_ch_reg;

    // scan control
    phase_t phase_reg, phase_next, cur_phase;
    logic   stopped_reg, stopped_next, cur_stopped;

    // result register
    logic               out_valid_reg, out_valid_next;
    ihc_pkg::result_t   out_reg;

    logic               advance;
    logic               fire;
    hex_digit_t         hex;
    ihc_pkg::asm_ctl_t  asm_ctl;
    ihc_pkg::eval_ctl_t eval_ctl;
    ihc_pkg::rec_t      rec;
    ihc_pkg::result_t   res;

    // the held character moves on once the result register is free
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign hex         = hex_decode(in_ch_reg);
    assign cur_phase   = in_new_file_reg ? PH_LINE_START : phase_reg;
    assign cur_stopped = in_new_file_reg ? 1'b0 : stopped_reg;

    always_comb begin
        asm_ctl        = '0;
        eval_ctl       = '0;
        asm_ctl.clear  = fire && in_new_file_reg;
        eval_ctl.clear = fire && in_new_file_reg;
        phase_next     = phase_reg;
        stopped_next   = stopped_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (fire) begin
            phase_next   = cur_phase;
            stopped_next = cur_stopped;
            if (!cur_stopped) begin
                case (cur_phase)
                    PH_LINE_START: begin
                        if (in_ch_reg == ihc_pkg::CHAR_COLON) begin
                            asm_ctl.start = 1'b1;
                            phase_next    = PH_DIGITS;
                        end else begin
                            eval_ctl.no_colon = 1'b1;
                            stopped_next      = 1'b1;
                            out_valid_next    = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        if (hex.valid && rec.digits < DIGIT_LIMIT) begin
                            asm_ctl.take = 1'b1;
                        end else begin
                            // a line feed as terminator also ends the line
                            phase_next      = (in_ch_reg == ihc_pkg::CHAR_LF) ? PH_LINE_START
                                                                              : PH_SKIP;
                            eval_ctl.finish = 1'b1;
                            stopped_next    = res.stopped;
                            out_valid_next  = 1'b1;
                        end
                    end
                    PH_SKIP: begin
                        if (in_ch_reg == ihc_pkg::CHAR_LF) phase_next = PH_LINE_START;
                    end
                    default: phase_next = PH_LINE_START;
                endcase
            end
        end
    end

    ihc_rec_asm u_rec_asm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (asm_ctl),
        .digit   (hex.value),
        .rec     (rec)
    );

    ihc_rec_eval #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_rec_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (eval_ctl),
        .rec     (rec),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_LINE_START;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            phase_reg     <= phase_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
        // payload, no reset needed
        if (s_tready && s_tvalid) begin
            in_new_file_reg <= s_tdata[0];
            in_ch_reg       <= s_tdata[8:1];
        end
        if (fire && (eval_ctl.no_colon || eval_ctl.finish)) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg.stopped, out_reg.file_valid, out_reg.max_addr,
                       out_reg.min_addr, out_reg.count, out_reg.address, out_reg.rtype,
                       out_reg.status};

    `IHC_ASSERT_RST(a_no_result_after_reset, !aresetn |=> !out_valid_reg,
                    "result pending straight after reset")
    `IHC_ASSERT(a_stopped_is_silent,
                (fire && stopped_reg && !in_new_file_reg) |=> !out_valid_reg,
                "stopped scan produced a result")
    `IHC_ASSERT(a_error_stops_scan,
                (out_valid_reg && out_reg.status != ihc_pkg::ST_OK) |-> out_reg.stopped,
                "error result without scan_stopped")
    `IHC_ASSERT(a_stop_comes_with_result, $rose(stopped_reg) |-> out_valid_reg,
                "scan stopped without a result")

endmodule

FILE: tb/sv/hex_record_verifier.sv
module hex_record_verifier (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,   // new_file[0], ch[8:1], zero pad
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,   // status, record_type, record_address, byte_count,
                                    // min_address, max_address, file_valid, scan_stopped
    output int           pending,
    output int           failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        AWAIT_COLON,
        IN_DIGITS,
        SKIP_LINE
    } line_phase_t;

    line_phase_t line_phase;
    logic [7:0]  n_digits;
    logic [3:0]  high_half;
    logic [7:0]  running_sum;
    logic [7:0]  count_field;
    logic [15:0] addr_field;
    logic [7:0]  type_field;
    logic [15:0] lead_bytes;
    logic [15:0] offset_hi;
    logic [31:0] lowest;
    logic [31:0] highest;
    logic        eof_done;
    logic        halted;

    ihc_pkg::result_t awaited_results[$];
    int               errors = 0;

    function automatic logic [4:0] nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        return 5'b0;
    endfunction

    task automatic clear_record();
        n_digits    = '0;
        high_half   = '0;
        running_sum = '0;
        count_field = '0;
        addr_field  = '0;
        type_field  = '0;
        lead_bytes  = ihc_pkg::FIRST_DATA_RESET;
    endtask

    task automatic clear_scan();
        line_phase = AWAIT_COLON;
        clear_record();
        offset_hi = '0;
        lowest    = ihc_pkg::LOWEST_RESET;
        highest   = '0;
        eof_done  = 1'b0;
        halted    = 1'b0;
    endtask

    task automatic add_digit(logic [3:0] v);
        logic [7:0] b;
        if (!n_digits[0]) begin
            high_half = v;
        end else begin
            b = {high_half, v};
            running_sum += b;
            case (n_digits[7:1])
                7'd0: count_field = b;
                7'd1: addr_field[15:8] = b;
                7'd2: addr_field[7:0] = b;
                7'd3: type_field = b;
                7'd4: if (count_field >= 8'd1) lead_bytes[15:8] = b;
                7'd5: if (count_field >= 8'd2) lead_bytes[7:0] = b;
                default: ;
            endcase
        end
        n_digits++;
    endtask

    // address is formed with the offset as it stands after the record took effect
    function automatic ihc_pkg::result_t make_result(ihc_pkg::status_t st, bit show);
        ihc_pkg::result_t r;
        r = '0;
        r.status = st;
        if (show) begin
            r.rtype   = type_field;
            r.address = {offset_hi, 16'h0000} + {16'h0000, addr_field};
            r.count   = count_field;
        end
        r.min_addr   = lowest;
        r.max_addr   = highest;
        r.file_valid = eof_done;
        r.stopped    = halted;
        return r;
    endfunction

    function automatic ihc_pkg::result_t close_record();
        logic [31:0]      abs_addr;
        logic [31:0]      top_addr;
        ihc_pkg::status_t st;
        if (n_digits < ihc_pkg::MIN_DIGITS) begin
            halted = 1'b1;
            return make_result(ihc_pkg::ST_TOO_SHORT, 1'b0);
        end
        if (count_field > ihc_pkg::MAX_COUNT) begin
            st = ihc_pkg::ST_COUNT_LARGE;
        end else if (int'(n_digits) != int'(ihc_pkg::MIN_DIGITS) + 2 * int'(count_field)
                     || running_sum != 8'd0) begin
            st = ihc_pkg::ST_BAD_SUM;
        end else if (type_field == ihc_pkg::REC_DATA) begin
            st = ihc_pkg::ST_OK;
            abs_addr = {offset_hi, 16'h0000} + {16'h0000, addr_field};
            top_addr = abs_addr + {24'h0, count_field};
            if (abs_addr < lowest) lowest = abs_addr;
            if (top_addr > highest) highest = top_addr;
        end else if (type_field == ihc_pkg::REC_EOF) begin
            st = ihc_pkg::ST_OK;
            eof_done = 1'b1;
            halted = 1'b1;
        end else if (type_field == ihc_pkg::REC_EXT_LINEAR) begin
            st = ihc_pkg::ST_OK;
            offset_hi = lead_bytes;
        end else begin
            st = ihc_pkg::ST_BAD_TYPE;
        end
        if (st != ihc_pkg::ST_OK) halted = 1'b1;
        return make_result(st, 1'b1);
    endfunction

    task automatic scan_character(logic nf, logic [7:0] c);
        logic [4:0] dig;
        dig = nibble_of(c);
        if (nf) clear_scan();
        if (halted) return;
        case (line_phase)
            AWAIT_COLON: begin
                if (c == ihc_pkg::CHAR_COLON) begin
                    clear_record();
                    line_phase = IN_DIGITS;
                end else begin
                    halted = 1'b1;
                    awaited_results.push_back(make_result(ihc_pkg::ST_NO_COLON, 1'b0));
                end
            end
            SKIP_LINE: begin
                if (c == ihc_pkg::CHAR_LF) line_phase = AWAIT_COLON;
            end
            default: begin
                if (dig[4] && n_digits < ihc_pkg::DIGIT_LIMIT) begin
                    add_digit(dig[3:0]);
                end else begin
                    line_phase = (c == ihc_pkg::CHAR_LF) ? AWAIT_COLON : SKIP_LINE;
                    awaited_results.push_back(close_record());
                end
            end
        endcase
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        ihc_pkg::result_t want;
        ihc_pkg::result_t got;
        if (!aresetn) begin
            clear_scan();
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready) scan_character(s_tdata[0], s_tdata[8:1]);
            if (m_tvalid && m_tready) begin
                got = ihc_pkg::result_t'(m_tdata[116:0]);
                if (awaited_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("record_type", 32'(want.rtype), 32'(got.rtype));
                    check_field("record_address", want.address, got.address);
                    check_field("byte_count", 32'(want.count), 32'(got.count));
                    check_field("min_address", want.min_addr, got.min_addr);
                    check_field("max_address", want.max_addr, got.max_addr);
                    check_field("file_valid", 32'(want.file_valid), 32'(got.file_valid));
                    check_field("scan_stopped", 32'(want.stopped), 32'(got.stopped));
                end
            end
        end
        pending  <= awaited_results.size();
        failures <= errors;
    end

endmodule

FILE: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS         = 1150;
    localparam int IDLE_LIMIT    = 4000;   // cycles without any transaction
    localparam int SETTLE_CYCLES = 20;     // results trail their character through the input and result registers

    // ways a generated record can be spoilt
    typedef enum {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_EXTRA,
        FLAW_DROP,
        FLAW_TRUNC,
        FLAW_NO_COLON
    } flaw_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;     // new_file[0], ch[8:1], zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;     // status, record_type, record_address, byte_count,
                               // min_address, max_address, file_valid, scan_stopped

    int   pending;             // results still owed by the block
    int   failures;
    int   send_idle;           // percent of cycles the character source holds back
    int   recv_idle;           // percent of cycles the result sink stalls
    int   chars_sent;
    int   quiet_cycles;
    logic file_head;           // next character opens a new file

    intel_hex_record_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hex_record_verifier verifier (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .pending  (pending),
        .failures (failures)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result sink: stalls at random at the current rate
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog: any transaction on either side restarts the count
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic bit is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] n, bit lower);
        if (n < 4'd10) return 8'("0" + n);
        return lower ? 8'("a" + n - 8'd10) : 8'("A" + n - 8'd10);
    endfunction

    // mostly short data fields keep records frequent, now and then up to the limit
    function automatic logic [7:0] data_count();
        if ($urandom_range(7) == 0) return 8'($urandom_range(0, ihc_pkg::MAX_DATA_BYTES));
        return 8'($urandom_range(0, 6));
    endfunction

    // one character transaction, with random hold-off before it is offered
    task automatic send_raw(input logic nf, input logic [7:0] c);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, c, nf};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_char(input logic [7:0] c);
        send_raw(file_head, c);
        file_head = 1'b0;
        chars_sent++;
    endtask

    // hold the source until every owed result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // builds one record line, checksum included, then spoils it as asked
    task automatic send_record(input logic [7:0] rtype, input logic [15:0] addr,
                               input logic [7:0] cnt, input logic [15:0] lead,
                               input flaw_t flaw);
        logic [7:0] bytes_q[$];
        logic [3:0] nib_q[$];
        logic [7:0] sum;
        logic [7:0] c;
        int         keep;
        bytes_q.push_back(cnt);
        bytes_q.push_back(addr[15:8]);
        bytes_q.push_back(addr[7:0]);
        bytes_q.push_back(rtype);
        for (int i = 0; i < int'(cnt); i++)
            bytes_q.push_back(i == 0 ? lead[15:8] : i == 1 ? lead[7:0] : 8'($urandom));
        sum = '0;
        foreach (bytes_q[i]) sum += bytes_q[i];
        sum = ~sum + 8'd1;
        if (flaw == FLAW_SUM) sum ^= 8'($urandom_range(1, 255));
        bytes_q.push_back(sum);
        foreach (bytes_q[i]) begin
            nib_q.push_back(bytes_q[i][7:4]);
            nib_q.push_back(bytes_q[i][3:0]);
        end
        case (flaw)
            FLAW_EXTRA: nib_q.push_back(4'($urandom));
            FLAW_DROP:  void'(nib_q.pop_back());
            FLAW_TRUNC: begin
                keep = int'($urandom_range(0, 9));
                while (nib_q.size() > keep) void'(nib_q.pop_back());
            end
            default: ;
        endcase
        if (flaw == FLAW_NO_COLON) begin
            do c = 8'($urandom); while (c == ihc_pkg::CHAR_COLON);
            send_char(c);
        end else begin
            send_char(ihc_pkg::CHAR_COLON);
        end
        foreach (nib_q[i]) send_char(hex_digit(nib_q[i], 1'($urandom_range(1))));
        // line ending: cr lf, bare lf, or some other terminator with junk up to lf
        case ($urandom_range(3))
            0: begin
                send_char(8'h0D);
                send_char(ihc_pkg::CHAR_LF);
            end
            1: send_char(ihc_pkg::CHAR_LF);
            default: begin
                do c = 8'($urandom); while (is_hex(c) || c == ihc_pkg::CHAR_LF);
                send_char(c);
                repeat ($urandom_range(0, 3)) begin
                    do c = 8'($urandom); while (c == ihc_pkg::CHAR_LF);
                    send_char(c);
                end
                send_char(ihc_pkg::CHAR_LF);
            end
        endcase
    endtask

    task automatic run_directed();
        // one clean file through the whole address story
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h0000, 8'd0, 16'h0000, FLAW_NONE);
        send_record(ihc_pkg::REC_DATA, 16'hFFFF, ihc_pkg::MAX_COUNT, 16'($urandom), FLAW_NONE);
        send_record(ihc_pkg::REC_EXT_LINEAR, 16'h0000, 8'd2, 16'h1234, FLAW_NONE);
        send_record(ihc_pkg::REC_DATA, 16'h8000, 8'd16, 16'($urandom), FLAW_NONE);
        // type 4 with one data byte: low byte reads as ff
        send_record(ihc_pkg::REC_EXT_LINEAR, 16'h0000, 8'd1, 16'hAB00, FLAW_NONE);
        send_record(ihc_pkg::REC_DATA, 16'h0100, 8'd3, 16'($urandom), FLAW_NONE);
        // type 4 with no data: offset becomes ffff, next record wraps past 32 bits
        send_record(ihc_pkg::REC_EXT_LINEAR, 16'hFFFF, 8'd0, 16'h0000, FLAW_NONE);
        send_record(ihc_pkg::REC_DATA, 16'hFFF0, ihc_pkg::MAX_COUNT, 16'($urandom), FLAW_NONE);
        send_record(ihc_pkg::REC_EOF, 16'h0000, 8'd0, 16'h0000, FLAW_NONE);
        // stopped scan swallows everything
        send_raw(1'b0, ihc_pkg::CHAR_COLON);
        send_raw(1'b0, 8'h00);
        send_raw(1'b0, 8'hFF);
        // one error per file
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h1234, 8'd4, 16'h0000, FLAW_NO_COLON);
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h1234, 8'd4, 16'h0000, FLAW_TRUNC);
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h2000, ihc_pkg::MAX_COUNT + 8'd1, 16'h0000,
                    FLAW_NONE);
        // line longer than the digit limit
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h3000, 8'd50, 16'h0000, FLAW_NONE);
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h4000, 8'd5, 16'h0000, FLAW_SUM);
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h5000, 8'd5, 16'h0000, FLAW_EXTRA);
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'h6000, 8'd0, 16'h0000, FLAW_DROP);
        file_head = 1'b1;
        send_record(8'h05, 16'h7000, 8'd4, 16'h0000, FLAW_NONE);
        file_head = 1'b1;
        send_record(8'hFF, 16'h7000, 8'd0, 16'h0000, FLAW_NONE);
        // new file in the middle of a record throws the partial line away
        send_raw(1'b1, ihc_pkg::CHAR_COLON);
        send_raw(1'b0, "1");
        send_raw(1'b0, "f");
        chars_sent += 3;
        file_head = 1'b1;
        send_record(ihc_pkg::REC_DATA, 16'hABCD, 8'd2, 16'h0000, FLAW_NONE);
        send_record(ihc_pkg::REC_EOF, 16'h0000, 8'd0, 16'h0000, FLAW_NONE);
    endtask

    task automatic send_random_file();
        int         n_rec;
        int         pick;
        bit         done;
        logic [7:0] t;
        logic [15:0] lead;
        flaw_t      flaw;
        n_rec = int'($urandom_range(1, 8));
        done = 1'b0;
        file_head = 1'b1;
        for (int r = 0; r < n_rec && !done; r++) begin
            pick = int'($urandom_range(99));
            if (pick < 52) begin
                send_record(ihc_pkg::REC_DATA, 16'($urandom), data_count(), 16'($urandom),
                            FLAW_NONE);
            end else if (pick < 64) begin
                case ($urandom_range(3))
                    0: lead = 16'h0000;
                    1: lead = 16'hFFFF;
                    default: lead = 16'($urandom);
                endcase
                send_record(ihc_pkg::REC_EXT_LINEAR, 16'($urandom), 8'($urandom_range(0, 3)),
                            lead, FLAW_NONE);
            end else if (pick < 66) begin
                // end of file with a data field still counts as end of file
                send_record(ihc_pkg::REC_EOF, 16'($urandom), 8'($urandom_range(0, 2)),
                            16'($urandom), FLAW_NONE);
                done = 1'b1;
            end else if (pick < 76) begin
                case ($urandom_range(2))
                    0: flaw = FLAW_SUM;
                    1: flaw = FLAW_EXTRA;
                    default: flaw = FLAW_DROP;
                endcase
                send_record(8'($urandom_range(0, 4)), 16'($urandom), data_count(),
                            16'($urandom), flaw);
                done = 1'b1;
            end else if (pick < 79) begin
                send_record(ihc_pkg::REC_DATA, 16'($urandom), data_count(), 16'($urandom),
                            FLAW_TRUNC);
                done = 1'b1;
            end else if (pick < 82) begin
                send_record(ihc_pkg::REC_DATA, 16'($urandom), data_count(), 16'($urandom),
                            FLAW_NO_COLON);
                done = 1'b1;
            end else if (pick < 86) begin
                t = ($urandom_range(7) == 0)
                    ? 8'($urandom_range(40, 255))
                    : 8'($urandom_range(ihc_pkg::MAX_DATA_BYTES + 1, 40));
                send_record(ihc_pkg::REC_DATA, 16'($urandom), t, 16'($urandom), FLAW_NONE);
                done = 1'b1;
            end else if (pick < 91) begin
                do t = 8'($urandom);
                while (t == ihc_pkg::REC_DATA || t == ihc_pkg::REC_EOF ||
                       t == ihc_pkg::REC_EXT_LINEAR);
                send_record(t, 16'($urandom), data_count(), 16'($urandom), FLAW_NONE);
                done = 1'b1;
            end else begin
                // raw noise, sometimes with a new file flag among it
                repeat ($urandom_range(1, 6)) begin
                    send_raw($urandom_range(3) == 0, 8'($urandom));
                    chars_sent++;
                end
                done = 1'b1;
            end
        end
        if (!done && $urandom_range(9) != 0)
            send_record(ihc_pkg::REC_EOF, 16'h0000, 8'd0, 16'h0000, FLAW_NONE);
        repeat ($urandom_range(0, 2)) send_raw(1'b0, 8'($urandom));
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        send_idle    = 14;
        recv_idle    = 56;
        chars_sent   = 0;
        file_head    = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // source mostly steady, sink stalling often
        run_directed();
        while (chars_sent < 3 * ITEMS / 5) send_random_file();
        drain();

        // the other way round
        send_idle = 56;
        recv_idle = 14;
        while (chars_sent < 4 * ITEMS / 5) send_random_file();

        // full rate both sides
        send_idle = 0;
        recv_idle = 0;
        while (chars_sent < ITEMS) send_random_file();

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
